// ===== design/pscr_pkg.sv =====
// ----------------------------------------------------------------------------
// pscr_pkg: shared types and constants
// Word formats, cell state records and the saturation helper for the
// pairwise soft collision repulsion pipeline.
// ----------------------------------------------------------------------------
package pscr_pkg;

    // Field widths of the words.
    localparam int POS_W = 24;
    localparam int LEN_W = 16;
    localparam int ACC_W = 32;

    // Square root chain: one result bit per cell.
    localparam int SQRT_STEPS = 32;
    localparam int RAD_W      = 64;
    localparam int SQ_REM_W   = 35;
    localparam int ROOT_W     = 32;

    // Divider chains: one quotient bit per cell.
    localparam int DIV_Q_W   = 41;
    localparam int DIV_D_W   = 32;
    localparam int DIV_N_W   = DIV_Q_W + DIV_D_W;
    localparam int DIV_LANES = 5;

    // Divider lane assignment.
    localparam int LANE_UX   = 0;
    localparam int LANE_UY   = 1;
    localparam int LANE_NEAR = 2;
    localparam int LANE_W1   = 3;
    localparam int LANE_W2   = 4;

    // Input word: one pair of bodies.
    typedef struct packed {
        logic signed [POS_W-1:0] first_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic [LEN_W-1:0]        first_radius;
        logic [LEN_W-1:0]        second_radius;
        logic [LEN_W-1:0]        first_mass;
        logic [LEN_W-1:0]        second_mass;
        logic signed [ACC_W-1:0] first_acc_in_x;
        logic signed [ACC_W-1:0] first_acc_in_y;
        logic signed [ACC_W-1:0] second_acc_in_x;
        logic signed [ACC_W-1:0] second_acc_in_y;
    } in_word_t;

    // Output word: updated accelerations and the clip flag.
    typedef struct packed {
        logic signed [ACC_W-1:0] first_acc_out_x;
        logic signed [ACC_W-1:0] first_acc_out_y;
        logic signed [ACC_W-1:0] second_acc_out_x;
        logic signed [ACC_W-1:0] second_acc_out_y;
        logic                    saturated;
    } out_word_t;

    // State handed from one square root cell to the next.
    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sqrt_state_t;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic [DIV_D_W-1:0] rem;
        logic [DIV_Q_W-1:0] num;
        logic [DIV_Q_W-1:0] quo;
        logic [DIV_D_W-1:0] den;
    } div_state_t;

    // The four incoming accelerations.
    typedef struct packed {
        logic signed [ACC_W-1:0] a1x;
        logic signed [ACC_W-1:0] a1y;
        logic signed [ACC_W-1:0] a2x;
        logic signed [ACC_W-1:0] a2y;
    } acc_set_t;

    // Side data that rides along the square root chain.
    typedef struct packed {
        logic [POS_W-1:0] adx;
        logic [POS_W-1:0] ady;
        logic             neg_x;
        logic             neg_y;
        logic [LEN_W:0]   rsum;
        logic [LEN_W:0]   msum;
        logic [LEN_W-1:0] m1;
        logic [LEN_W-1:0] m2;
        acc_set_t         acc;
    } side_a_t;

    // Side data that rides along the divider chains.
    typedef struct packed {
        logic     neg_x;
        logic     neg_y;
        logic     d_zero;
        logic     s_zero;
        logic     m_zero;
        acc_set_t acc;
    } side_b_t;

    // Side data for the multiply stages.
    typedef struct packed {
        logic     tneg_x;
        logic     tneg_y;
        acc_set_t acc;
    } side_c_t;

    // Clip a wide sum to the accumulation range; the top bit flags a clip.
    function automatic logic [ACC_W:0] sat_acc(input logic signed [45:0] v);
        logic [ACC_W:0] r;
        r = {1'b0, v[ACC_W-1:0]};
        if (v > 46'sd2147483647)
        begin
            r = {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (v < -46'sd2147483648)
        begin
            r = {1'b1, 1'b1, {(ACC_W-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

// ===== design/pscr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// pscr_sqrt_cell: one step of the digit-by-digit square root
// Brings down two radicand bits, tries the next root bit and hands the
// updated state to the next cell.
// ----------------------------------------------------------------------------
module pscr_sqrt_cell (
    input  logic                  clk,
    input  logic                  en,
    input  pscr_pkg::sqrt_state_t cur,
    output pscr_pkg::sqrt_state_t nxt
);

    pscr_pkg::sqrt_state_t nxt_reg;
    logic [pscr_pkg::SQ_REM_W-1:0] tr;
    logic [pscr_pkg::SQ_REM_W-1:0] trial;
    logic                          ge;

    // Partial remainder with two new bits against (root << 2) | 1.
    always_comb
    begin
        tr    = {cur.rem[pscr_pkg::SQ_REM_W-3:0], cur.rad[pscr_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        ge    = (tr >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg.rad  <= {cur.rad[pscr_pkg::RAD_W-3:0], 2'b00};
            nxt_reg.rem  <= ge ? (tr - trial) : tr;
            nxt_reg.root <= {cur.root[pscr_pkg::ROOT_W-2:0], ge};
        end
    end

    assign nxt = nxt_reg;

endmodule

// ===== design/pscr_div_cell.sv =====
// ----------------------------------------------------------------------------
// pscr_div_cell: one step of restoring division
// Shifts in the next numerator bit, subtracts the divisor when it fits and
// hands one more quotient bit to the next cell.
// ----------------------------------------------------------------------------
module pscr_div_cell (
    input  logic                 clk,
    input  logic                 en,
    input  pscr_pkg::div_state_t cur,
    output pscr_pkg::div_state_t nxt
);

    pscr_pkg::div_state_t nxt_reg;
    logic [pscr_pkg::DIV_D_W:0] tr;
    logic [pscr_pkg::DIV_D_W:0] diff;
    logic                       ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        tr   = {cur.rem, cur.num[pscr_pkg::DIV_Q_W-1]};
        diff = tr - {1'b0, cur.den};
        ge   = (tr >= {1'b0, cur.den});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg.rem <= ge ? diff[pscr_pkg::DIV_D_W-1:0] : tr[pscr_pkg::DIV_D_W-1:0];
            nxt_reg.num <= {cur.num[pscr_pkg::DIV_Q_W-2:0], 1'b0};
            nxt_reg.quo <= {cur.quo[pscr_pkg::DIV_Q_W-2:0], ge};
            nxt_reg.den <= cur.den;
        end
    end

    assign nxt = nxt_reg;

endmodule

// ===== design/pairwise_soft_collision_repulsion_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_soft_collision_repulsion_top: soft sphere repulsion pipeline
// Takes two bodies per word and returns their updated accelerations.
//
//   channel | direction | payload           | handshake
//   pair    | in        | pscr_pkg::in_word_t  | pair_valid / pair_stall
//   acc     | out       | pscr_pkg::out_word_t | acc_valid / acc_stall
//
// One word is taken every cycle unless a held output word stalls the chain;
// each word passes the input register, squares, sum, 32 square root cells,
// 41 divider cells, nearness, two multiply stages and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output freezes the whole chain, including the input side.
// ----------------------------------------------------------------------------
module pairwise_soft_collision_repulsion_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    output logic                pair_stall,
    input  pscr_pkg::in_word_t  pair_word,
    output logic                acc_valid,
    input  logic                acc_stall,
    output pscr_pkg::out_word_t acc_word
);

    localparam int SQ = pscr_pkg::SQRT_STEPS;
    localparam int DV = pscr_pkg::DIV_Q_W;
    localparam int NL = pscr_pkg::DIV_LANES;

    logic adv;

    // Front stages.
    logic               v0_reg, v1_reg, v2_reg;
    pscr_pkg::in_word_t w0_reg;
    logic [47:0]        sqx_reg, sqy_reg;
    pscr_pkg::side_a_t  s1_reg, s2_reg;
    logic [63:0]        rad_reg;

    logic signed [24:0] dx, dy;
    logic [23:0]        adx, ady;

    // Square root chain.
    pscr_pkg::sqrt_state_t sq_st [SQ+1];
    logic                  vq_reg [SQ];
    pscr_pkg::side_a_t     sa_reg [SQ];

    // Divider chains.
    pscr_pkg::div_state_t dv_st [NL][DV+1];
    logic                 vd_reg [DV];
    pscr_pkg::side_b_t    sb_reg [DV];
    pscr_pkg::side_a_t    sa_end;
    pscr_pkg::side_b_t    sb_in;
    logic [31:0]          root_dist;
    logic [72:0]          n_ux, n_uy, n_near, n_w1, n_w2;

    // Back stages.
    pscr_pkg::side_b_t  sb_end;
    logic signed [42:0] near_s;
    logic [41:0]        near_mag;
    logic               vn_reg, vf_reg, vt_reg, out_valid_reg;
    logic [41:0]        nmag_reg;
    logic [20:0]        ux_reg, uy_reg, uxf_reg, uyf_reg;
    logic [16:0]        w1_reg, w2_reg;
    pscr_pkg::side_c_t  sn_reg, sf_reg, st_reg;
    logic [58:0]        p1, p2;
    logic [42:0]        f1_reg, f2_reg;
    logic [63:0]        px1, py1, px2, py2;
    logic [43:0]        t1x_reg, t1y_reg, t2x_reg, t2y_reg;
    logic signed [45:0] r1x, r1y, r2x, r2y;
    logic [32:0]        c1x, c1y, c2x, c2y;
    pscr_pkg::out_word_t out_reg;

    // The chain moves whenever the output register is free or being taken.
    assign adv        = !(out_valid_reg && acc_stall);
    assign pair_stall = !adv;

    // Difference vector magnitudes and signs.
    always_comb
    begin
        dx  = 25'(w0_reg.first_pos_x) - 25'(w0_reg.second_pos_x);
        dy  = 25'(w0_reg.first_pos_y) - 25'(w0_reg.second_pos_y);
        adx = dx[24] ? 24'(-dx) : dx[23:0];
        ady = dy[24] ? 24'(-dy) : dy[23:0];
    end

    // Input register, squares and the scaled radicand.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= pair_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w0_reg       <= pair_word;
            sqx_reg      <= adx * adx;
            sqy_reg      <= ady * ady;
            s1_reg.adx   <= adx;
            s1_reg.ady   <= ady;
            s1_reg.neg_x <= dx[24];
            s1_reg.neg_y <= dy[24];
            s1_reg.rsum  <= 17'(w0_reg.first_radius) + 17'(w0_reg.second_radius);
            s1_reg.msum  <= 17'(w0_reg.first_mass) + 17'(w0_reg.second_mass);
            s1_reg.m1    <= w0_reg.first_mass;
            s1_reg.m2    <= w0_reg.second_mass;
            s1_reg.acc   <= {w0_reg.first_acc_in_x, w0_reg.first_acc_in_y,
                             w0_reg.second_acc_in_x, w0_reg.second_acc_in_y};
            rad_reg      <= 64'(49'(sqx_reg) + 49'(sqy_reg)) << 14;
            s2_reg       <= s1_reg;
        end
    end

    // Square root chain: one root bit per cell.
    assign sq_st[0] = '{rad: rad_reg, rem: '0, root: '0};

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        pscr_sqrt_cell u_cell (
            .clk (clk),
            .en  (adv),
            .cur (sq_st[i]),
            .nxt (sq_st[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vq_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vq_reg[i] <= (i == 0) ? v2_reg : vq_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sa_reg[i] <= (i == 0) ? s2_reg : sa_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Divider operands from the distance and the side data.
    always_comb
    begin
        root_dist    = sq_st[SQ].root;
        sa_end       = sa_reg[SQ-1];
        n_ux         = {22'b0, sa_end.adx, 27'b0};
        n_uy         = {22'b0, sa_end.ady, 27'b0};
        n_near       = {32'b0, root_dist, 9'b0};
        n_w1         = {41'b0, sa_end.m1, 16'b0};
        n_w2         = {41'b0, sa_end.m2, 16'b0};
        sb_in.neg_x  = sa_end.neg_x;
        sb_in.neg_y  = sa_end.neg_y;
        sb_in.d_zero = (root_dist == '0);
        sb_in.s_zero = (sa_end.rsum == '0);
        sb_in.m_zero = (sa_end.msum == '0);
        sb_in.acc    = sa_end.acc;
    end

    assign dv_st[pscr_pkg::LANE_UX][0]   = '{rem: n_ux[72:41], num: n_ux[40:0],
                                             quo: '0, den: root_dist};
    assign dv_st[pscr_pkg::LANE_UY][0]   = '{rem: n_uy[72:41], num: n_uy[40:0],
                                             quo: '0, den: root_dist};
    assign dv_st[pscr_pkg::LANE_NEAR][0] = '{rem: n_near[72:41], num: n_near[40:0],
                                             quo: '0, den: {15'b0, sa_end.rsum}};
    assign dv_st[pscr_pkg::LANE_W1][0]   = '{rem: n_w1[72:41], num: n_w1[40:0],
                                             quo: '0, den: {15'b0, sa_end.msum}};
    assign dv_st[pscr_pkg::LANE_W2][0]   = '{rem: n_w2[72:41], num: n_w2[40:0],
                                             quo: '0, den: {15'b0, sa_end.msum}};

    // Five divider lanes run side by side, one quotient bit per cell.
    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        for (genvar i = 0; i < DV; i++)
        begin : g_div
            pscr_div_cell u_cell (
                .clk (clk),
                .en  (adv),
                .cur (dv_st[k][i]),
                .nxt (dv_st[k][i+1])
            );
        end
    end

    for (genvar i = 0; i < DV; i++)
    begin : g_dside
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vd_reg[i] <= (i == 0) ? vq_reg[SQ-1] : vd_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sb_reg[i] <= (i == 0) ? sb_in : sb_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Nearness and its magnitude; a zero radius sum forces zero.
    always_comb
    begin
        sb_end   = sb_reg[DV-1];
        near_s   = 43'sd65536 - $signed({2'b0, dv_st[pscr_pkg::LANE_NEAR][DV].quo});
        near_mag = near_s[42] ? 42'(-near_s) : near_s[41:0];
        if (sb_end.s_zero)
        begin
            near_mag = '0;
        end
    end

    // Products: weights times nearness, then direction times force.
    always_comb
    begin
        p1  = nmag_reg * w2_reg;
        p2  = nmag_reg * w1_reg;
        px1 = uxf_reg * f1_reg;
        py1 = uyf_reg * f1_reg;
        px2 = uxf_reg * f2_reg;
        py2 = uyf_reg * f2_reg;
    end

    // Final sums with sign applied, then clipping.
    always_comb
    begin
        r1x = 46'(st_reg.acc.a1x) + (st_reg.tneg_x ? -$signed({2'b0, t1x_reg})
                                                   :  $signed({2'b0, t1x_reg}));
        r1y = 46'(st_reg.acc.a1y) + (st_reg.tneg_y ? -$signed({2'b0, t1y_reg})
                                                   :  $signed({2'b0, t1y_reg}));
        r2x = 46'(st_reg.acc.a2x) - (st_reg.tneg_x ? -$signed({2'b0, t2x_reg})
                                                   :  $signed({2'b0, t2x_reg}));
        r2y = 46'(st_reg.acc.a2y) - (st_reg.tneg_y ? -$signed({2'b0, t2y_reg})
                                                   :  $signed({2'b0, t2y_reg}));
        c1x = pscr_pkg::sat_acc(r1x);
        c1y = pscr_pkg::sat_acc(r1y);
        c2x = pscr_pkg::sat_acc(r2x);
        c2y = pscr_pkg::sat_acc(r2y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            vt_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vn_reg        <= vd_reg[DV-1];
            vf_reg        <= vn_reg;
            vt_reg        <= vf_reg;
            out_valid_reg <= vt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nmag_reg      <= near_mag;
            ux_reg        <= sb_end.d_zero ? '0 : dv_st[pscr_pkg::LANE_UX][DV].quo[20:0];
            uy_reg        <= sb_end.d_zero ? '0 : dv_st[pscr_pkg::LANE_UY][DV].quo[20:0];
            w1_reg        <= sb_end.m_zero ? '0 : dv_st[pscr_pkg::LANE_W1][DV].quo[16:0];
            w2_reg        <= sb_end.m_zero ? '0 : dv_st[pscr_pkg::LANE_W2][DV].quo[16:0];
            sn_reg.tneg_x <= sb_end.neg_x ^ near_s[42];
            sn_reg.tneg_y <= sb_end.neg_y ^ near_s[42];
            sn_reg.acc    <= sb_end.acc;

            f1_reg        <= p1[58:16];
            f2_reg        <= p2[58:16];
            uxf_reg       <= ux_reg;
            uyf_reg       <= uy_reg;
            sf_reg        <= sn_reg;

            t1x_reg       <= px1[63:20];
            t1y_reg       <= py1[63:20];
            t2x_reg       <= px2[63:20];
            t2y_reg       <= py2[63:20];
            st_reg        <= sf_reg;

            out_reg.first_acc_out_x  <= c1x[31:0];
            out_reg.first_acc_out_y  <= c1y[31:0];
            out_reg.second_acc_out_x <= c2x[31:0];
            out_reg.second_acc_out_y <= c2y[31:0];
            out_reg.saturated        <= c1x[32] | c1y[32] | c2x[32] | c2y[32];
        end
    end

    assign acc_valid = out_valid_reg;
    assign acc_word  = out_reg;

    // The root remainder never exceeds twice the root.
    a_sqrt_rem : assert property (@(posedge clk) disable iff (!rst_n)
        vq_reg[SQ-1] |-> (sq_st[SQ].rem <= {2'b0, sq_st[SQ].root, 1'b0}))
        else $error("square root remainder out of range");

    // The two mass weights sum to one, less at most one unit of truncation.
    a_weights : assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg[DV-1] && !sb_reg[DV-1].m_zero) |->
        ((42'(dv_st[pscr_pkg::LANE_W1][DV].quo) + 42'(dv_st[pscr_pkg::LANE_W2][DV].quo)
            == 42'd65536) ||
         (42'(dv_st[pscr_pkg::LANE_W1][DV].quo) + 42'(dv_st[pscr_pkg::LANE_W2][DV].quo)
            == 42'd65535)))
        else $error("mass weights do not sum to one");

    // Direction components stay within unit length.
    a_unit_dir : assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg[DV-1] && !sb_reg[DV-1].d_zero) |->
        ((dv_st[pscr_pkg::LANE_UX][DV].quo <= 41'd1048576) &&
         (dv_st[pscr_pkg::LANE_UY][DV].quo <= 41'd1048576)))
        else $error("direction component exceeds unit length");

endmodule

// ===== bench/pairwise_soft_collision_repulsion_checker.sv =====
// ----------------------------------------------------------------------------
// pairwise_soft_collision_repulsion_checker: prediction and scoreboard
// Watches the pair and acc channels, predicts the updated accelerations of
// every accepted pair word and compares each returned word in order.
// ----------------------------------------------------------------------------
module pairwise_soft_collision_repulsion_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    input  logic                pair_stall,
    input  pscr_pkg::in_word_t  pair_word,
    input  logic                acc_valid,
    input  logic                acc_stall,
    input  pscr_pkg::out_word_t acc_word,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    pscr_pkg::out_word_t accel_queue[$];

    // Floor square root of a 64-bit value, one result bit per pass.
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // One signed push term: direction times weighted nearness.
    function automatic longint push_term(input longint comp, input longint unsigned u,
                                         input longint nearness, input longint unsigned w);
        longint unsigned f;
        longint unsigned t;
        f = (magnitude(nearness) * w) >> 16;
        t = (u * f) >> 20;
        return ((comp < 0) != (nearness < 0)) ? -longint'(t) : longint'(t);
    endfunction

    // Clip to the accumulation range and note whether a clip happened.
    function automatic logic signed [pscr_pkg::ACC_W-1:0] clip_acc(input longint v,
                                                                   inout logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[pscr_pkg::ACC_W-1:0];
    endfunction

    function automatic pscr_pkg::out_word_t predict_accel(input pscr_pkg::in_word_t p);
        pscr_pkg::out_word_t o;
        longint              dx, dy, nearness;
        longint unsigned     adx, ady, dist_root, rsum, msum, ux, uy, w1, w2;
        logic                hit;
        dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
        dy = longint'(p.first_pos_y) - longint'(p.second_pos_y);
        adx = magnitude(dx);
        ady = magnitude(dy);
        dist_root = root_floor((adx * adx + ady * ady) << 14);
        rsum = longint'(p.first_radius) + longint'(p.second_radius);
        msum = longint'(p.first_mass) + longint'(p.second_mass);
        ux = 0;
        uy = 0;
        w1 = 0;
        w2 = 0;
        nearness = 0;
        hit = 1'b0;
        if (dist_root != 0)
        begin
            ux = (adx << 27) / dist_root;
            uy = (ady << 27) / dist_root;
        end
        if (rsum != 0)
            nearness = 65536 - longint'((dist_root << 9) / rsum);
        if (msum != 0)
        begin
            w1 = (longint'(p.first_mass) << 16) / msum;
            w2 = (longint'(p.second_mass) << 16) / msum;
        end
        o.first_acc_out_x = clip_acc(longint'(p.first_acc_in_x)
                                     + push_term(dx, ux, nearness, w2), hit);
        o.first_acc_out_y = clip_acc(longint'(p.first_acc_in_y)
                                     + push_term(dy, uy, nearness, w2), hit);
        o.second_acc_out_x = clip_acc(longint'(p.second_acc_in_x)
                                      - push_term(dx, ux, nearness, w1), hit);
        o.second_acc_out_y = clip_acc(longint'(p.second_acc_in_y)
                                      - push_term(dy, uy, nearness, w1), hit);
        o.saturated = hit;
        return o;
    endfunction

    // Record accepted pair words and check returned acc words in order.
    always @(posedge clk or negedge rst_n)
    begin
        pscr_pkg::out_word_t e;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            accel_queue.delete();
        end
        else
        begin
            if (pair_valid && !pair_stall)
                accel_queue.push_back(predict_accel(pair_word));
            if (acc_valid && !acc_stall)
            begin
                if (accel_queue.size() == 0)
                begin
                    $display("%0t: unexpected acc word %h", $time, acc_word);
                    errors <= errors + 1;
                end
                else
                begin
                    e = accel_queue.pop_front();
                    if (e !== acc_word)
                    begin
                        errors <= errors + 1;
                        if (e.first_acc_out_x !== acc_word.first_acc_out_x)
                            $display("%0t: first_acc_out_x expected %0d actual %0d", $time,
                                     e.first_acc_out_x, acc_word.first_acc_out_x);
                        if (e.first_acc_out_y !== acc_word.first_acc_out_y)
                            $display("%0t: first_acc_out_y expected %0d actual %0d", $time,
                                     e.first_acc_out_y, acc_word.first_acc_out_y);
                        if (e.second_acc_out_x !== acc_word.second_acc_out_x)
                            $display("%0t: second_acc_out_x expected %0d actual %0d", $time,
                                     e.second_acc_out_x, acc_word.second_acc_out_x);
                        if (e.second_acc_out_y !== acc_word.second_acc_out_y)
                            $display("%0t: second_acc_out_y expected %0d actual %0d", $time,
                                     e.second_acc_out_y, acc_word.second_acc_out_y);
                        if (e.saturated !== acc_word.saturated)
                            $display("%0t: saturated expected %0b actual %0b", $time,
                                     e.saturated, acc_word.saturated);
                    end
                end
            end
            pending <= accel_queue.size();
        end
    end

endmodule

// ===== bench/pairwise_soft_collision_repulsion_top_tb.sv =====
// ----------------------------------------------------------------------------
// pairwise_soft_collision_repulsion_top_tb: stimulus and verdict
// Drives directed corner pairs and then random pairs in bursts while the
// output side stalls on its own pattern; the checker does the comparing.
// ----------------------------------------------------------------------------
module pairwise_soft_collision_repulsion_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1950;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 120;

    logic                clk;
    logic                rst_n;
    logic                pair_valid;
    logic                pair_stall;
    pscr_pkg::in_word_t  pair_word;
    logic                acc_valid;
    logic                acc_stall;
    pscr_pkg::out_word_t acc_word;
    int                  errors;
    int                  pending;
    int                  cycles;
    int                  burst_left;

    pairwise_soft_collision_repulsion_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_word  (pair_word),
        .acc_valid  (acc_valid),
        .acc_stall  (acc_stall),
        .acc_word   (acc_word)
    );

    pairwise_soft_collision_repulsion_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_word  (pair_word),
        .acc_valid  (acc_valid),
        .acc_stall  (acc_stall),
        .acc_word   (acc_word),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        acc_stall = 1'b0;
        pair_valid = 1'b0;
        pair_word = '0;
        rst_n = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("pairwise_soft_collision_repulsion_top_tb: FAIL");
            $finish;
        end
    end
    initial cycles = 0;

    // Output stall pattern: modes of free flow, light random stalls, long runs and heavy random stalls.
    always @(posedge clk)
    begin
        int mode;
        mode = (cycles / 300) % 4;
        case (mode)
            0: acc_stall <= 1'b0;
            1: acc_stall <= ($urandom_range(0, 3) == 0);
            2: acc_stall <= ((cycles % 23) < 9);
            default: acc_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Offer one word and hold it until it is taken.
    task automatic send_word(input pscr_pkg::in_word_t w);
        pair_word <= w;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
    endtask

    // Bursts of random length separated by random gaps.
    task automatic paced_send(input pscr_pkg::in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                pair_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_word(w);
    endtask

    function automatic logic [pscr_pkg::LEN_W-1:0] nonzero16();
        logic [pscr_pkg::LEN_W-1:0] v;
        v = 16'($urandom());
        if (v == 0)
            v = 1;
        return v;
    endfunction

    function automatic pscr_pkg::in_word_t random_pair();
        pscr_pkg::in_word_t w;
        int                 kind;
        kind = $urandom_range(0, 9);
        w.first_pos_x = 24'($urandom());
        w.first_pos_y = 24'($urandom());
        w.first_radius = nonzero16();
        w.second_radius = nonzero16();
        w.first_mass = nonzero16();
        w.second_mass = nonzero16();
        w.first_acc_in_x = $urandom();
        w.first_acc_in_y = $urandom();
        w.second_acc_in_x = $urandom();
        w.second_acc_in_y = $urandom();
        if (kind < 3)
        begin
            // Fully random words.
            w.second_pos_x = 24'($urandom());
            w.second_pos_y = 24'($urandom());
        end
        else
        begin
            // Nearby bodies with moderate radii, the usual contact case.
            w.second_pos_x = w.first_pos_x + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
            w.second_pos_y = w.first_pos_y + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
            w.first_radius = 16'($urandom_range(1, 4096));
            w.second_radius = 16'($urandom_range(1, 4096));
            w.first_acc_in_x = $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
            w.first_acc_in_y = $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
            if (kind == 9)
            begin
                // Accumulations near the bounds to provoke clipping.
                w.first_acc_in_x = 32'sh7FFFFFFF - $urandom_range(0, 65535);
                w.second_acc_in_y = 32'sh80000000 + $urandom_range(0, 65535);
            end
        end
        return w;
    endfunction

    initial
    begin
        pscr_pkg::in_word_t w;
        int                 i;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: coincident centres, extremes, separation and clipping.
        for (i = 0; i < 16; i++)
        begin
            w = random_pair();
            case (i)
                0: w.second_pos_x = w.first_pos_x;
                default: ;
            endcase
            if (i == 0)
                w.second_pos_y = w.first_pos_y;
            if (i == 1)
            begin
                w.first_pos_x = 24'sh7FFFFF;
                w.first_pos_y = 24'sh7FFFFF;
                w.second_pos_x = 24'sh800000;
                w.second_pos_y = 24'sh800000;
                w.first_radius = 1;
                w.second_radius = 1;
            end
            if (i == 2)
            begin
                w.first_pos_x = 24'sh800000;
                w.second_pos_x = 24'sh7FFFFF;
                w.first_pos_y = 0;
                w.second_pos_y = 0;
                w.first_radius = 16'hFFFF;
                w.second_radius = 16'hFFFF;
                w.first_mass = 16'hFFFF;
                w.second_mass = 16'hFFFF;
            end
            if (i == 3)
            begin
                w.first_mass = 1;
                w.second_mass = 1;
            end
            if (i == 4)
            begin
                w.first_mass = 1;
                w.second_mass = 16'hFFFF;
            end
            if (i == 5)
            begin
                w.first_radius = 16'hFFFF;
                w.second_radius = 16'hFFFF;
                w.second_pos_x = w.first_pos_x + 24'sd1;
                w.second_pos_y = w.first_pos_y;
            end
            if (i == 6)
            begin
                w.first_acc_in_x = 32'sh7FFFFFFF;
                w.first_acc_in_y = 32'sh7FFFFFFF;
                w.second_acc_in_x = 32'sh80000000;
                w.second_acc_in_y = 32'sh80000000;
                w.first_pos_x = 24'sh7FFFFF;
                w.second_pos_x = 24'sh800000;
                w.first_radius = 1;
                w.second_radius = 1;
            end
            if (i == 7)
            begin
                w.first_acc_in_x = 32'sh80000000;
                w.first_acc_in_y = 32'sh80000000;
                w.second_acc_in_x = 32'sh7FFFFFFF;
                w.second_acc_in_y = 32'sh7FFFFFFF;
                w.first_pos_x = 24'sh800000;
                w.second_pos_x = 24'sh7FFFFF;
                w.first_pos_y = 24'sh800000;
                w.second_pos_y = 24'sh7FFFFF;
                w.first_radius = 1;
                w.second_radius = 1;
            end
            if (i == 8)
            begin
                w.first_pos_x = 0;
                w.first_pos_y = 0;
                w.second_pos_x = 0;
                w.second_pos_y = 24'sd1;
            end
            if (i == 9)
                w = '1;
            if (i == 10)
            begin
                w = '0;
                w.first_radius = 1;
                w.second_radius = 1;
                w.first_mass = 1;
                w.second_mass = 1;
                w.second_pos_x = 24'sd256;
            end
            send_word(w);
        end

        // Random part.
        for (i = 0; i < RANDOM_WORDS; i++)
            paced_send(random_pair());
        pair_valid <= 1'b0;

        // Let the checker count the last accepted word before waiting on it.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("pairwise_soft_collision_repulsion_top_tb: PASS");
        else
            $display("pairwise_soft_collision_repulsion_top_tb: FAIL");
        $finish;
    end

endmodule
